/* hdl/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// Linear-probe hash table: shared package
// Types, codes and default sizes used by every file of the hash table block.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Default sizes of the table.
	localparam int DEF_TABLE_ENTRIES = 256;
	localparam int DEF_KEY_BITS      = 16;
	localparam int DEF_VALUE_BITS    = 16;

	// Fixed widths of the stream fields.
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 16;
	localparam int SLOT_W  = 8;

	// Result codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Operations of the shared index unit.
	typedef enum logic {
		ALU_SHIFT_IN = 1'b0,
		ALU_INC      = 1'b1
	} alu_op_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_READ,
		S_CHECK,
		S_DONE
	} fsm_state_t;

	// One result word.
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [VALUE_W-1:0]  stored_value;
	} res_t;

endpackage

/* hdl/lpht_alu.sv */
// ----------------------------------------------------------------------------
// Linear-probe hash table: index unit
// One compare-and-subtract against the table size, shared by the home-slot
// remainder steps, the probe advance and the clearing sweep.
// ----------------------------------------------------------------------------
module lpht_alu
	import lpht_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
	input  alu_op_t                            op,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   a,
	input  logic                               bit_in,
	output logic [$clog2(TABLE_ENTRIES)-1:0]   y,
	output logic                               wrap
);

	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam logic [IDXW:0] LIMIT = (IDXW+1)'(TABLE_ENTRIES);

	logic [IDXW:0] x;
	logic [IDXW:0] d;

	always_comb begin
		case (op)
			ALU_SHIFT_IN: x = {a, bit_in};
			ALU_INC:      x = {1'b0, a} + (IDXW+1)'(1);
			default:      x = {1'b0, a};
		endcase
		wrap = (x >= LIMIT);
		d    = wrap ? (x - LIMIT) : x;
		y    = d[IDXW-1:0];
	end

endmodule

/* hdl/lpht_store.sv */
// ----------------------------------------------------------------------------
// Linear-probe hash table: slot store
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lpht_store
	import lpht_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KW            = DEF_KEY_BITS,
	parameter int VW            = DEF_VALUE_BITS
) (
	input  logic                               clk,
	input  logic                               we,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   waddr,
	input  logic [KW-1:0]                      wkey,
	input  logic [VW-1:0]                      wval,
	input  logic                               re,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   raddr,
	output logic [KW-1:0]                      rkey,
	output logic [VW-1:0]                      rval
);

	logic [KW-1:0] key_mem [TABLE_ENTRIES];
	logic [VW-1:0] val_mem [TABLE_ENTRIES];
	logic [KW-1:0] rkey_q;
	logic [VW-1:0] rval_q;

	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[waddr] <= wkey;
			val_mem[waddr] <= wval;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rkey_q <= key_mem[raddr];
			rval_q <= val_mem[raddr];
		end
	end

	assign rkey = rkey_q;
	assign rval = rval_q;

endmodule

/* hdl/lpht_seq.sv */
// ----------------------------------------------------------------------------
// Linear-probe hash table: sequencer
// Clears the table after reset, works out the home slot and walks the probe
// sequence one slot at a time, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module lpht_seq
	import lpht_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KW            = DEF_KEY_BITS,
	parameter int VW            = DEF_VALUE_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Item side
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               in_mode,
	input  logic [KW-1:0]                      in_key,
	input  logic [VW-1:0]                      in_val,
	// Result side
	output logic                               done,
	input  logic                               take,
	output res_t                               res,
	// Store
	output logic                               mem_we,
	output logic [$clog2(TABLE_ENTRIES)-1:0]   mem_waddr,
	output logic [KW-1:0]                      mem_wkey,
	output logic [VW-1:0]                      mem_wval,
	output logic                               mem_re,
	output logic [$clog2(TABLE_ENTRIES)-1:0]   mem_raddr,
	input  logic [KW-1:0]                      mem_rkey,
	input  logic [VW-1:0]                      mem_rval,
	// Index unit
	output alu_op_t                            alu_op,
	output logic [$clog2(TABLE_ENTRIES)-1:0]   alu_a,
	output logic                               alu_bit,
	input  logic [$clog2(TABLE_ENTRIES)-1:0]   alu_y,
	input  logic                               alu_wrap
);

	localparam int  IDXW    = $clog2(TABLE_ENTRIES);
	localparam int  BW      = $clog2(KW);
	localparam int  MW      = (KW > IDXW) ? KW : IDXW;
	localparam int  SLW     = (IDXW > SLOT_W) ? IDXW : SLOT_W;
	localparam bit  IS_POW2 = ((1 << IDXW) == TABLE_ENTRIES);

	fsm_state_t       state_q, state_d;
	logic             full_q;
	logic [IDXW-1:0]  idx_q;
	logic [IDXW-1:0]  cnt_q;
	logic [BW-1:0]    bit_q;
	logic             mode_q;
	logic [KW-1:0]    key_q;
	logic [VW-1:0]    val_q;
	res_t             res_q;

	logic             accept;
	logic             key_zero;
	logic [MW-1:0]    key_ext;
	logic [IDXW-1:0]  home;
	logic             hit, empty, last, stop;
	logic [SLW-1:0]   slot_ext;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign key_zero = (in_key == '0);
	assign key_ext  = MW'(in_key);
	assign home     = key_ext[IDXW-1:0];
	assign hit      = (mem_rkey == key_q);
	assign empty    = (mem_rkey == '0);
	assign last     = (cnt_q == IDXW'(TABLE_ENTRIES - 1));
	assign stop     = mode_q ? (empty || last) : (hit || empty || last);
	assign slot_ext = SLW'(idx_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (alu_wrap) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (key_zero || (in_mode && full_q)) state_d = S_DONE;
					else if (IS_POW2)                    state_d = S_READ;
					else                                 state_d = S_MOD;
				end
			end
			S_MOD: begin
				if (bit_q == '0) state_d = S_READ;
			end
			S_READ:  state_d = S_CHECK;
			S_CHECK: begin
				state_d = stop ? S_DONE : S_READ;
			end
			S_DONE: begin
				if (take) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = 1'b0;
		done      = 1'b0;
		mem_we    = 1'b0;
		mem_wkey  = key_q;
		mem_re    = 1'b0;
		alu_op    = ALU_INC;
		alu_bit   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we   = 1'b1;
				mem_wkey = '0;
			end
			S_IDLE:  in_ready = 1'b1;
			S_MOD: begin
				alu_op  = ALU_SHIFT_IN;
				alu_bit = key_q[bit_q];
			end
			S_READ:  mem_re = 1'b1;
			S_CHECK: mem_we = mode_q && empty;
			S_DONE:  done = 1'b1;
			default: ;
		endcase
	end

	assign mem_waddr = idx_q;
	assign mem_wval  = val_q;
	assign mem_raddr = idx_q;
	assign alu_a     = idx_q;
	assign res       = res_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			full_q  <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: idx_q <= alu_y;
				S_IDLE: begin
					if (accept) idx_q <= IS_POW2 ? home : '0;
				end
				S_MOD:   idx_q <= alu_y;
				S_CHECK: begin
					if (!stop) idx_q <= alu_y;
					if (mode_q && !empty && last) full_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Item and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q             <= in_mode;
					key_q              <= in_key;
					val_q              <= in_val;
					bit_q              <= BW'(KW - 1);
					cnt_q              <= '0;
					res_q.status       <= key_zero ? ST_MISS : ST_FULL;
					res_q.slot         <= '0;
					res_q.stored_value <= '0;
				end
			end
			S_MOD: bit_q <= bit_q - BW'(1);
			S_CHECK: begin
				cnt_q <= cnt_q + IDXW'(1);
				if (mode_q) begin
					if (empty) begin
						res_q.status       <= ST_OK;
						res_q.slot         <= slot_ext[SLOT_W-1:0];
						res_q.stored_value <= VALUE_W'(val_q);
					end else begin
						res_q.status       <= ST_FULL;
						res_q.slot         <= '0;
						res_q.stored_value <= '0;
					end
				end else if (hit) begin
					res_q.status       <= ST_OK;
					res_q.slot         <= slot_ext[SLOT_W-1:0];
					res_q.stored_value <= VALUE_W'(mem_rval);
				end else begin
					res_q.status       <= ST_MISS;
					res_q.slot         <= '0;
					res_q.stored_value <= '0;
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	// Once the table is marked full it stays so until reset.
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("table full flag cleared");

	// Only an insert can report a full table.
	a_full_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status == ST_FULL) |-> mode_q)
		else $error("full status on a lookup");

	// Any unsuccessful answer carries zero slot and value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_q.status != ST_OK) |->
		(res_q.slot == '0 && res_q.stored_value == '0))
		else $error("failed answer with nonzero payload");

	// The clearing sweep only ever hands over to the idle state.
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |=> (state_q == S_CLEAR || state_q == S_IDLE))
		else $error("clearing sweep left early");
`endif

endmodule

/* hdl/linear_probe_hash_table.sv */
// ----------------------------------------------------------------------------
// Linear-probe hash table
// Open-addressing hash table with linear probing, lookups and inserts over a
// stream interface.
// ----------------------------------------------------------------------------
//
//  Group   Dir  tdata                                   tuser
//  s_*     in   [15:0] key, [31:16] value               [0] mode (0 lookup, 1 insert)
//  m_*     out  [7:0] slot, [23:8] stored_value         [1:0] status (0 ok, 1 miss, 2 full)
//
// After reset the block sweeps the key memory, one slot per cycle, writing
// every key to zero; s_tready stays low until the sweep is done.
// An item is then accepted, forms its home slot with one remainder step per
// stored key bit (KEY_BITS, at most 16) when TABLE_ENTRIES is not a power of
// two (with none otherwise), reads then compares each slot probed, and
// passes the result word to the output register. A key of zero, or an
// insert into a table already marked full, goes straight to the result.
// The probe count is set by the table load.
// One item is in work at a time; the output register lets the next item be
// accepted while the previous result word still waits on m_tready. If that
// register is still full when the next result word is ready, the sequencer
// holds the word, and s_tready stays low, until m_tready takes the older one.
//
// Key zero marks an empty slot, so such a key is always answered as not
// found. Inserts do not look for duplicates; a lookup returns the first copy
// on the probe path. An insert that goes all the way round without meeting
// an empty slot marks the table full, and every later insert is refused.
//
module linear_probe_hash_table
	import lpht_pkg::*;
#(
	parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
	parameter int KEY_BITS      = DEF_KEY_BITS,
	parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] key, [31:16] value
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] slot, [23:8] stored_value
	output logic [1:0]  m_tuser    // [1:0] status
);

	// Only the low bits of key and value that the table stores take part.
	localparam int IDXW = $clog2(TABLE_ENTRIES);
	localparam int KW   = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int VW   = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

	logic             done, take;
	res_t             res;
	logic             mem_we, mem_re;
	logic [IDXW-1:0]  mem_waddr, mem_raddr;
	logic [KW-1:0]    mem_wkey, mem_rkey;
	logic [VW-1:0]    mem_wval, mem_rval;
	alu_op_t          alu_op;
	logic [IDXW-1:0]  alu_a, alu_y;
	logic             alu_bit, alu_wrap;

	logic             out_valid_q;
	res_t             out_res_q;

	lpht_seq #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KW            (KW),
		.VW            (VW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_key    (s_tdata[KW-1:0]),
		.in_val    (s_tdata[KEY_W+VW-1:KEY_W]),
		.done      (done),
		.take      (take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wkey  (mem_wkey),
		.mem_wval  (mem_wval),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rkey  (mem_rkey),
		.mem_rval  (mem_rval),
		.alu_op    (alu_op),
		.alu_a     (alu_a),
		.alu_bit   (alu_bit),
		.alu_y     (alu_y),
		.alu_wrap  (alu_wrap)
	);

	lpht_store #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KW            (KW),
		.VW            (VW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wkey  (mem_wkey),
		.wval  (mem_wval),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rkey  (mem_rkey),
		.rval  (mem_rval)
	);

	lpht_alu #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_alu (
		.op     (alu_op),
		.a      (alu_a),
		.bit_in (alu_bit),
		.y      (alu_y),
		.wrap   (alu_wrap)
	);

	// Output register: the finished result word moves in whenever the
	// register is empty or its current word is being taken this cycle.
	assign take = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && take) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_res_q.stored_value, out_res_q.slot};
	assign m_tuser  = out_res_q.status;

endmodule

/* sim/tb_linear_probe_hash_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear-probe hash table: regression testbench
// Sends lookup and insert words through the input stream and checks every
// result word against a behavioural copy of the table kept in the testbench.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
	import lpht_pkg::*;

	// The stream carries a single mode bit in tuser.
	typedef enum logic {
		OP_LOOKUP = 1'b0,
		OP_INSERT = 1'b1
	} op_t;

	localparam int SLOTS        = DEF_TABLE_ENTRIES;
	localparam int IDLE_PCT     = 28;
	localparam int RANDOM_OPS   = 410;
	// The random phase stops inserting at this occupancy, so that the table
	// is only filled on purpose in the fill phase near the end of the run.
	localparam int FILL_CAP     = 200;
	localparam int DRAIN_CYCLES = 24;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [15:0] key, [31:16] value
	logic        s_tuser;   // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // [7:0] slot, [23:8] stored_value
	logic [1:0]  m_tuser;   // [1:0] status

	// Behavioural copy of the table, updated at the edge that accepts a word.
	logic [KEY_W-1:0]   key_mirror   [SLOTS];
	logic [VALUE_W-1:0] value_mirror [SLOTS];
	bit                 full_mirror;
	int                 filled_slots;
	logic [KEY_W-1:0]   live_keys [$];

	// Results still owed by the block, oldest first.
	res_t pending_results [$];
	int   error_count;
	// When set, neither side of the stream idles.
	bit   steady;

	linear_probe_hash_table #(
		.TABLE_ENTRIES (DEF_TABLE_ENTRIES),
		.KEY_BITS      (DEF_KEY_BITS),
		.VALUE_BITS    (DEF_VALUE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Works out the result of one operation and applies it to the copy of the
	// table. A lookup walks up from the home slot until it meets the key, an
	// empty slot or has been all the way round; an insert takes the first
	// empty slot on the same walk and marks the table full if there is none.
	function automatic res_t probe_table(input op_t op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		res_t r;
		int   idx;
		bit   stop;
		r.status       = ST_MISS;
		r.slot         = '0;
		r.stored_value = '0;
		stop           = 1'b0;
		// Key zero is the empty marker and is never found or stored.
		if (k == '0)
			return r;
		idx = k % SLOTS;
		if (op == OP_LOOKUP) begin
			for (int n = 0; n < SLOTS && !stop; n++) begin
				if (key_mirror[idx] == k) begin
					r.status       = ST_OK;
					r.slot         = SLOT_W'(idx);
					r.stored_value = value_mirror[idx];
					stop           = 1'b1;
				end else if (key_mirror[idx] == '0) begin
					stop = 1'b1;
				end else begin
					idx = (idx + 1) % SLOTS;
				end
			end
		end else if (full_mirror) begin
			r.status = ST_FULL;
		end else begin
			for (int n = 0; n < SLOTS && !stop; n++) begin
				if (key_mirror[idx] == '0) begin
					key_mirror[idx]   = k;
					value_mirror[idx] = v;
					r.status          = ST_OK;
					r.slot            = SLOT_W'(idx);
					r.stored_value    = v;
					stop              = 1'b1;
					filled_slots++;
					live_keys.push_back(k);
				end else begin
					idx = (idx + 1) % SLOTS;
				end
			end
			// A full circle without an empty slot makes the flag stick.
			if (!stop) begin
				full_mirror = 1'b1;
				r.status    = ST_FULL;
			end
		end
		return r;
	endfunction

	// Random non-zero key; about a third land on a narrow band of home slots
	// so that long probe runs and wrap-around build up.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = KEY_W'($urandom);
		if ($urandom_range(99) < 30)
			k[7:0] = 8'($urandom_range(16, 23));
		if (k == '0)
			k[KEY_W-1] = 1'b1;
		return k;
	endfunction

	// Offers one word and waits for the handshake. The valid line is only
	// lowered for an idle gap, so back-to-back words keep it high throughout.
	task automatic send_op(input op_t op, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] v);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {v, k};
		s_tuser  <= op;
		@(posedge clk);
		while (s_tready !== 1'b1)
			@(posedge clk);
		pending_results.push_back(probe_table(op, k, v));
	endtask

	function automatic logic [KEY_W-1:0] some_live_key();
		return live_keys[$urandom_range(live_keys.size() - 1)];
	endfunction

	// Key zero in both modes, on an empty table.
	task automatic test_key_zero();
		send_op(OP_LOOKUP, '0, 16'hFFFF);
		send_op(OP_INSERT, '0, 16'hFFFF);
	endtask

	// Lookups on an empty table stop at the home slot.
	task automatic test_empty_lookup();
		send_op(OP_LOOKUP, 16'hFFFF, 16'h0000);
		send_op(OP_LOOKUP, 16'h1234, 16'hFFFF);
	endtask

	// Extreme keys and values, stored and read back.
	task automatic test_extremes();
		send_op(OP_INSERT, 16'hFFFF, 16'hFFFF);
		send_op(OP_INSERT, 16'h0001, 16'h0000);
		send_op(OP_INSERT, 16'h8000, 16'h5555);
		send_op(OP_INSERT, 16'h7FFE, 16'hAAAA);
		send_op(OP_LOOKUP, 16'hFFFF, 16'h0000);
		send_op(OP_LOOKUP, 16'h0001, 16'hFFFF);
		send_op(OP_LOOKUP, 16'h8000, 16'h0000);
		send_op(OP_LOOKUP, 16'h7FFE, 16'h0000);
	endtask

	// Keys homed on the last slot collide and wrap round to the bottom of the
	// table; lookups then have to step over the other keys on the run.
	task automatic test_collisions_and_wrap();
		send_op(OP_INSERT, 16'h01FF, 16'h1234);
		send_op(OP_INSERT, 16'h02FF, 16'hEDCB);
		send_op(OP_LOOKUP, 16'h02FF, 16'h0000);
		send_op(OP_LOOKUP, 16'h03FF, 16'h0000);
		send_op(OP_LOOKUP, 16'h0101, 16'h0000);
	endtask

	// Inserts never check for an existing copy; a lookup sees the first one.
	task automatic test_duplicates();
		send_op(OP_INSERT, 16'h0505, 16'h0001);
		send_op(OP_INSERT, 16'h0505, 16'h0002);
		send_op(OP_LOOKUP, 16'h0505, 16'h0000);
	endtask

	// Mostly inserts and lookups of stored keys, with misses and key zero as
	// noise. A stretch in the middle runs with no idling on either side.
	task automatic test_random_traffic();
		int roll;
		for (int i = 0; i < RANDOM_OPS; i++) begin
			steady <= (i >= 150 && i < 250);
			roll = $urandom_range(99);
			if (roll < 5)
				send_op(op_t'($urandom_range(1)), '0, VALUE_W'($urandom));
			else if (roll < 40 && filled_slots < FILL_CAP)
				send_op(OP_INSERT, fresh_key(), VALUE_W'($urandom));
			else if (roll < 80 && live_keys.size() != 0)
				send_op(OP_LOOKUP, some_live_key(), VALUE_W'($urandom));
			else
				send_op(OP_LOOKUP, fresh_key(), VALUE_W'($urandom));
		end
		steady <= 1'b0;
	endtask

	// Inserts until one goes all the way round and finds no empty slot.
	task automatic test_fill_to_full();
		while (!full_mirror)
			send_op(OP_INSERT, fresh_key(), VALUE_W'($urandom));
	endtask

	// With the flag set, inserts are refused at once, misses take a full
	// circle, and stored keys are still found.
	task automatic test_full_table();
		int roll;
		send_op(OP_INSERT, fresh_key(), VALUE_W'($urandom));
		send_op(OP_INSERT, '0, VALUE_W'($urandom));
		send_op(OP_LOOKUP, '0, VALUE_W'($urandom));
		send_op(OP_LOOKUP, fresh_key(), VALUE_W'($urandom));
		send_op(OP_LOOKUP, some_live_key(), VALUE_W'($urandom));
		for (int i = 0; i < 20; i++) begin
			roll = $urandom_range(99);
			if (roll < 30)
				send_op(OP_INSERT, fresh_key(), VALUE_W'($urandom));
			else if (roll < 75)
				send_op(OP_LOOKUP, some_live_key(), VALUE_W'($urandom));
			else
				send_op(OP_LOOKUP, fresh_key(), VALUE_W'($urandom));
		end
	endtask

	// The receiver stalls at random except during the steady stretch.
	always @(posedge clk)
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);

	// Every result word is compared with the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result word: status %0d slot %0d stored_value %0h",
					m_tuser, m_tdata[7:0], m_tdata[23:8]);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, m_tuser);
					error_count++;
				end
				if (m_tdata[7:0] !== want.slot) begin
					$error("slot: expected %0d, actual %0d", want.slot, m_tdata[7:0]);
					error_count++;
				end
				if (m_tdata[23:8] !== want.stored_value) begin
					$error("stored_value: expected %0h, actual %0h",
						want.stored_value, m_tdata[23:8]);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		full_mirror  = 1'b0;
		filled_slots = 0;
		error_count  = 0;
		steady       = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			key_mirror[i]   = '0;
			value_mirror[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block clears its key memory first; send_op simply waits on
		// s_tready until that sweep has finished.
		test_key_zero();
		test_empty_lookup();
		test_extremes();
		test_collisions_and_wrap();
		test_duplicates();
		test_random_traffic();
		test_fill_to_full();
		test_full_table();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// A short margin catches any stray word after the last expected one.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: several times the slowest legal run, full-circle probes included.
	initial begin
		#25_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hdl/lpht_pkg.sv
hdl/lpht_alu.sv
hdl/lpht_store.sv
hdl/lpht_seq.sv
hdl/linear_probe_hash_table.sv
sim/tb_linear_probe_hash_table.sv
